FILE: rtl/ecc_pkg.sv
// Shared types, constants and calendar table for the epoch calendar converter.
`timescale 1ns / 1ps

package ecc_pkg;

  // Days in one four-year leap cycle.
  localparam logic [31:0] FOUR_YEAR_DAYS = 32'((365 * 4) + 1);
  localparam logic [16:0] SECS_PER_DAY   = 17'(60 * 60 * 24);
  localparam logic [11:0] BASE_YEAR_RST  = 12'd2000;

  // Reciprocals: floor(x * M >> k) gives the exact quotient over the operand range.
  // (t >> 2) / 15, operand below 2^30
  localparam logic [31:0] RECIP_60    = 32'h8888_8889;
  // (t >> 4) / 225, operand below 2^28
  localparam logic [28:0] RECIP_3600  = 29'd305419897;
  // (t >> 7) / 675, operand below 2^25
  localparam logic [25:0] RECIP_86400 = 26'd50903317;
  // days / 1461, operand below 2^16
  localparam logic [21:0] RECIP_CYCLE = 22'd2939745;

  // Day of the four-year cycle on which each month starts.
  localparam logic [10:0] MONTH_START [4][12] = '{
    '{11'd0,    11'd31,   11'd60,   11'd91,   11'd121,  11'd152,
      11'd182,  11'd213,  11'd244,  11'd274,  11'd305,  11'd335},
    '{11'd366,  11'd397,  11'd425,  11'd456,  11'd486,  11'd517,
      11'd547,  11'd578,  11'd609,  11'd639,  11'd670,  11'd700},
    '{11'd731,  11'd762,  11'd790,  11'd821,  11'd851,  11'd882,
      11'd912,  11'd943,  11'd974,  11'd1004, 11'd1035, 11'd1065},
    '{11'd1096, 11'd1127, 11'd1155, 11'd1186, 11'd1216, 11'd1247,
      11'd1277, 11'd1308, 11'd1339, 11'd1369, 11'd1400, 11'd1430}
  };

  // Input word
  typedef struct packed {
    logic        mode;
    logic [31:0] in_seconds_count;
    logic [11:0] in_year;
    logic [3:0]  in_month;
    logic [4:0]  in_day;
    logic [4:0]  in_hour;
    logic [5:0]  in_minute;
    logic [5:0]  in_second;
  } ecc_in_t;

  // Result word
  typedef struct packed {
    logic [31:0] out_seconds_count;
    logic [11:0] out_year;
    logic [3:0]  out_month;
    logic [4:0]  out_day;
    logic [4:0]  out_hour;
    logic [5:0]  out_minute;
    logic [5:0]  out_second;
    logic        bad_month;
  } ecc_out_t;

  // Cycle day of the first day of a month (1..12); zero for other codes.
  function automatic logic [10:0] month_start_f(logic [1:0] row, logic [3:0] month);
    logic [10:0] res;
    res = '0;
    if (month >= 4'd1 && month <= 4'd12) begin
      res = MONTH_START[row][month - 4'd1];
    end
    return res;
  endfunction

endpackage

FILE: rtl/ecc_in_if.sv
// Handshake channel carrying input words of the epoch calendar converter.
`timescale 1ns / 1ps

interface ecc_in_if
  import ecc_pkg::*;
();
  logic    valid;
  logic    ready;
  ecc_in_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

FILE: rtl/ecc_out_if.sv
// Handshake channel carrying result words of the epoch calendar converter.
`timescale 1ns / 1ps

interface ecc_out_if
  import ecc_pkg::*;
();
  logic     valid;
  logic     ready;
  ecc_out_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

FILE: rtl/epoch_calendar_convert.sv
// Epoch calendar converter: seven-stage pipeline between seconds count and date.
//
// Converts each input word either from date and time to a 32-bit seconds count
// (mode 0) or from a seconds count to date and time (mode 1), relative to the
// start of base_year, with every fourth year from the base a leap year. One word
// is taken per clock while the pipeline is not stalled; the depth is set by the
// seconds-to-date path: constant divisions done as reciprocal multiplies, each
// followed by its remainder stage, then the year and month searches. Every stage
// has its own valid bit and stalls only when the stage after it is full, so
// bubbles close up under back-pressure. A month outside 1..12 in mode 0 raises
// bad_month with all other fields zero. base_year resets to 2000 and is written
// through cfg_we_i/cfg_wdata_i; the user must write it only while the block is
// idle, as the block itself does not enforce this.
`timescale 1ns / 1ps

module epoch_calendar_convert
  import ecc_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [11:0] cfg_wdata_i,
  ecc_in_if.sink      in_i,
  ecc_out_if.source   out_o
);

  localparam int unsigned NumStages = 7;

  // Base year register
  logic [11:0] base_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_q <= BASE_YEAR_RST;
    end else if (cfg_we_i) begin
      base_q <= cfg_wdata_i;
    end
  end

  // Stage valids and advance enables
  logic [NumStages:1] v_q;
  logic [NumStages:1] adv;

  always_comb begin
    adv[NumStages] = !v_q[NumStages] || out_o.ready;
    for (int k = NumStages - 1; k >= 1; k--) begin
      adv[k] = !v_q[k] || adv[k+1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (adv[1]) begin
        v_q[1] <= in_i.valid;
      end
      for (int k = 2; k <= NumStages; k++) begin
        if (adv[k]) begin
          v_q[k] <= v_q[k-1];
        end
      end
    end
  end

  assign in_i.ready  = adv[1];
  assign out_o.valid = v_q[NumStages];

  // Mode and bad-month flag travel with the word
  logic [NumStages-1:1] mode_q;
  logic [NumStages-1:1] bad_q;

  always_ff @(posedge clk_i) begin
    if (adv[1]) begin
      mode_q[1] <= in_i.data.mode;
      bad_q[1]  <= (in_i.data.in_month == 4'd0) || (in_i.data.in_month > 4'd12);
    end
    for (int k = 2; k <= NumStages - 1; k++) begin
      if (adv[k]) begin
        mode_q[k] <= mode_q[k-1];
        bad_q[k]  <= bad_q[k-1];
      end
    end
  end

  // Stage 1: year offset, cycle days, time of day; reciprocal products
  logic [31:0] ydiff;
  logic [10:0] ms;
  logic [31:0] s1_cyc_days_d, s1_cyc_days_q;
  logic [31:0] s1_msd_d, s1_msd_q;
  logic [16:0] s1_tod_d, s1_tod_q;
  logic [31:0] s1_t_q;
  logic [61:0] s1_p60_d, s1_p60_q;
  logic [56:0] s1_p3600_d, s1_p3600_q;
  logic [50:0] s1_p86400_d, s1_p86400_q;

  always_comb begin
    ydiff         = 32'(in_i.data.in_year) - 32'(base_q);
    ms            = month_start_f(ydiff[1:0], in_i.data.in_month);
    s1_cyc_days_d = 32'({2'b00, ydiff[31:2]} * FOUR_YEAR_DAYS);
    s1_msd_d      = 32'(ms) + 32'(in_i.data.in_day) - 32'd1;
    s1_tod_d      = 17'(in_i.data.in_hour) * 17'd3600
                  + 17'(in_i.data.in_minute) * 17'd60
                  + 17'(in_i.data.in_second);
    s1_p60_d      = 62'(in_i.data.in_seconds_count[31:2]) * 62'(RECIP_60);
    s1_p3600_d    = 57'(in_i.data.in_seconds_count[31:4]) * 57'(RECIP_3600);
    s1_p86400_d   = 51'(in_i.data.in_seconds_count[31:7]) * 51'(RECIP_86400);
  end

  always_ff @(posedge clk_i) begin
    if (adv[1]) begin
      s1_cyc_days_q <= s1_cyc_days_d;
      s1_msd_q      <= s1_msd_d;
      s1_tod_q      <= s1_tod_d;
      s1_t_q        <= in_i.data.in_seconds_count;
      s1_p60_q      <= s1_p60_d;
      s1_p3600_q    <= s1_p3600_d;
      s1_p86400_q   <= s1_p86400_d;
    end
  end

  // Stage 2: day count; quotients and second/minute/hour remainders
  logic [26:0] q60;
  logic [20:0] q3600;
  logic [15:0] q86400;
  logic [31:0] rem60;
  logic [26:0] rem3600;
  logic [20:0] rem24;
  logic [31:0] s2_days_q;
  logic [16:0] s2_tod_q;
  logic [15:0] s2_dnum_q;
  logic [5:0]  s2_sec_q, s2_min_q;
  logic [4:0]  s2_hr_q;

  always_comb begin
    q60     = s1_p60_q[61:35];
    q3600   = s1_p3600_q[56:36];
    q86400  = s1_p86400_q[50:35];
    rem60   = s1_t_q - 32'(q60) * 32'd60;
    rem3600 = q60 - 27'(q3600) * 27'd60;
    rem24   = q3600 - 21'(q86400) * 21'd24;
  end

  always_ff @(posedge clk_i) begin
    if (adv[2]) begin
      s2_days_q <= s1_cyc_days_q + s1_msd_q;
      s2_tod_q  <= s1_tod_q;
      s2_dnum_q <= q86400;
      s2_sec_q  <= rem60[5:0];
      s2_min_q  <= rem3600[5:0];
      s2_hr_q   <= rem24[4:0];
    end
  end

  // Stage 3: seconds count; product for the four-year cycle
  logic [31:0] s3_secs_q;
  logic [37:0] s3_pcyc_q;
  logic [15:0] s3_dnum_q;
  logic [5:0]  s3_sec_q, s3_min_q;
  logic [4:0]  s3_hr_q;

  always_ff @(posedge clk_i) begin
    if (adv[3]) begin
      s3_secs_q <= 32'(s2_days_q * 32'(SECS_PER_DAY)) + 32'(s2_tod_q);
      s3_pcyc_q <= 38'(s2_dnum_q) * 38'(RECIP_CYCLE);
      s3_dnum_q <= s2_dnum_q;
      s3_sec_q  <= s2_sec_q;
      s3_min_q  <= s2_min_q;
      s3_hr_q   <= s2_hr_q;
    end
  end

  // Stage 4: cycle count and day of the cycle
  logic [5:0]  cyc;
  logic [15:0] cyc_rem;
  logic [31:0] s4_secs_q;
  logic [5:0]  s4_cyc_q;
  logic [10:0] s4_r_q;
  logic [5:0]  s4_sec_q, s4_min_q;
  logic [4:0]  s4_hr_q;

  always_comb begin
    cyc     = s3_pcyc_q[37:32];
    cyc_rem = s3_dnum_q - 16'(cyc) * 16'(FOUR_YEAR_DAYS);
  end

  always_ff @(posedge clk_i) begin
    if (adv[4]) begin
      s4_secs_q <= s3_secs_q;
      s4_cyc_q  <= cyc;
      s4_r_q    <= cyc_rem[10:0];
      s4_sec_q  <= s3_sec_q;
      s4_min_q  <= s3_min_q;
      s4_hr_q   <= s3_hr_q;
    end
  end

  // Stage 5: year within the cycle and calendar year
  logic [1:0]  yi;
  logic [31:0] s5_secs_q;
  logic [1:0]  s5_yi_q;
  logic [11:0] s5_year_q;
  logic [10:0] s5_r_q;
  logic [5:0]  s5_sec_q, s5_min_q;
  logic [4:0]  s5_hr_q;

  always_comb begin
    priority if (s4_r_q >= month_start_f(2'd3, 4'd1)) begin
      yi = 2'd3;
    end else if (s4_r_q >= month_start_f(2'd2, 4'd1)) begin
      yi = 2'd2;
    end else if (s4_r_q >= month_start_f(2'd1, 4'd1)) begin
      yi = 2'd1;
    end else begin
      yi = 2'd0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv[5]) begin
      s5_secs_q <= s4_secs_q;
      s5_yi_q   <= yi;
      s5_year_q <= {4'b0000, s4_cyc_q, yi} + base_q;
      s5_r_q    <= s4_r_q;
      s5_sec_q  <= s4_sec_q;
      s5_min_q  <= s4_min_q;
      s5_hr_q   <= s4_hr_q;
    end
  end

  // Stage 6: month search over the selected year row, day of month
  logic [3:0]  mon;
  logic [10:0] mon_start;
  logic [10:0] day_full;
  logic [31:0] s6_secs_q;
  logic [11:0] s6_year_q;
  logic [3:0]  s6_mon_q;
  logic [4:0]  s6_day_q;
  logic [5:0]  s6_sec_q, s6_min_q;
  logic [4:0]  s6_hr_q;

  always_comb begin
    mon = 4'd1;
    for (int m = 2; m <= 12; m++) begin
      if (s5_r_q >= month_start_f(s5_yi_q, 4'(m))) begin
        mon = 4'(m);
      end
    end
    mon_start = month_start_f(s5_yi_q, mon);
    day_full  = s5_r_q - mon_start + 11'd1;
  end

  always_ff @(posedge clk_i) begin
    if (adv[6]) begin
      s6_secs_q <= s5_secs_q;
      s6_year_q <= s5_year_q;
      s6_mon_q  <= mon;
      s6_day_q  <= day_full[4:0];
      s6_sec_q  <= s5_sec_q;
      s6_min_q  <= s5_min_q;
      s6_hr_q   <= s5_hr_q;
    end
  end

  // Output register: pick the direction, zero the other side
  ecc_out_t out_d, out_q;

  always_comb begin
    out_d = '0;
    if (!mode_q[NumStages-1]) begin
      if (bad_q[NumStages-1]) begin
        out_d.bad_month = 1'b1;
      end else begin
        out_d.out_seconds_count = s6_secs_q;
      end
    end else begin
      out_d.out_year   = s6_year_q;
      out_d.out_month  = s6_mon_q;
      out_d.out_day    = s6_day_q;
      out_d.out_hour   = s6_hr_q;
      out_d.out_minute = s6_min_q;
      out_d.out_second = s6_sec_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv[NumStages]) begin
      out_q <= out_d;
    end
  end

  assign out_o.data = out_q;

  // Checks
  a_bad_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && out_o.data.bad_month
      |-> out_o.data.out_seconds_count == 32'd0 && out_o.data.out_month == 4'd0)
    else $error("bad_month result carries nonzero fields");

  a_date_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && out_o.data.out_month != 4'd0
      |-> out_o.data.out_month <= 4'd12 && out_o.data.out_day != 5'd0
          && out_o.data.out_hour < 5'd24)
    else $error("date result out of range");

  a_take_fills: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_i.valid && in_i.ready |=> v_q[1])
    else $error("accepted word lost at first stage");

  a_full_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (&v_q) && !out_o.ready |-> !in_i.ready)
    else $error("full pipeline accepts a word while stalled");

endmodule
